// File: hw/rtl/whes_pkg.sv
// ----------------------------------------------------------------------------
// Water heater element sequencer package
// Shared types, codes and helper functions for the element sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package whes_pkg;

  // Field widths
  localparam int unsigned ModeW     = 2;
  localparam int unsigned TempCfgW  = 15;
  localparam int unsigned CountW    = 8;
  localparam int unsigned TempW     = 16;
  localparam int unsigned TodW      = 17;
  localparam int unsigned NowW      = 32;
  localparam int unsigned ElemW     = 2;
  localparam int unsigned DriveW    = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 17;
  // Product of count and increment needs 24 signed bits, the sum one more.
  localparam int unsigned ProdW     = 24;
  localparam int unsigned SetptW    = 25;
  localparam int unsigned TrigW     = 18;
  localparam int unsigned RiseW     = 17;

  // Behavior constants
  localparam logic [NowW-1:0]         RunCheckSeconds   = 32'd7200;
  localparam logic signed [RiseW-1:0] MinRiseHundredths = 17'sd200;
  localparam logic [TrigW-1:0]        CycleDelaySeconds = 18'd60;
  localparam logic [ElemW-1:0]        LastElementIdx    = 2'd2;

  // Operating modes
  typedef enum logic [ModeW-1:0] {
    MODE_MANUAL       = 2'd0,
    MODE_WINTER       = 2'd1,
    MODE_INTERMEDIATE = 2'd2,
    MODE_SUMMER       = 2'd3
  } whes_mode_e;

  // Input actions
  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_POLL  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_SETPT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PERSONS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PER_PERSON = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EMERGENCY  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CYCLE_START = 3'd5;

  // Configuration values as seen by the step logic
  typedef struct packed {
    whes_mode_e                  mode;
    logic signed [SetptW-1:0]    setpoint;
    logic signed [TempCfgW-1:0]  threshold;
    logic [TrigW-1:0]            trigger;
  } whes_cfg_t;

  // Sequencer state
  typedef struct packed {
    logic                     heating;
    logic                     daily_done;
    logic [ElemW-1:0]         last_elem;
    logic [DriveW-1:0]        relays;
    logic signed [TempW-1:0]  start_temp;
    logic [NowW-1:0]          start_time;
  } whes_state_t;

  // One input item
  typedef struct packed {
    logic                     action;
    logic signed [TempW-1:0]  tank_temp;
    logic [TodW-1:0]          time_of_day;
    logic                     stove_running;
    logic [NowW-1:0]          now_seconds;
  } whes_item_t;

  // Next element in the 0,1,2 rotation
  function automatic logic [ElemW-1:0] next_elem(input logic [ElemW-1:0] cur);
    logic [ElemW-1:0] nxt;
    if (cur >= LastElementIdx) begin
      nxt = '0;
    end else begin
      nxt = cur + 2'd1;
    end
    return nxt;
  endfunction

  // Start heating on the next element, recording temperature and time
  function automatic whes_state_t do_start(input whes_state_t s,
                                           input logic signed [TempW-1:0] temp,
                                           input logic [NowW-1:0] now);
    whes_state_t r;
    r            = s;
    r.last_elem  = next_elem(s.last_elem);
    r.relays     = DriveW'(3'd1 << r.last_elem);
    r.start_temp = temp;
    r.start_time = now;
    r.heating    = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/whes_cfg_regs.sv
// ----------------------------------------------------------------------------
// Water heater element sequencer configuration registers
// Holds the six registers and derives the stop setpoint and daily trigger.
// ----------------------------------------------------------------------------
`default_nettype none

module whes_cfg_regs
  import whes_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output whes_cfg_t                cfg_o
);

  whes_mode_e                 mode_q;
  logic signed [TempCfgW-1:0] base_q;
  logic [CountW-1:0]          persons_q;
  logic signed [TempCfgW-1:0] per_person_q;
  logic signed [TempCfgW-1:0] emergency_q;
  logic [TodW-1:0]            cycle_start_q;

  logic signed [ProdW-1:0]    prod;

  // Register writes by index; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_MANUAL;
      base_q        <= '0;
      persons_q     <= '0;
      per_person_q  <= '0;
      emergency_q   <= '0;
      cycle_start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:        mode_q        <= whes_mode_e'(cfg_wdata_i[ModeW-1:0]);
        CFG_BASE_SETPT:  base_q        <= $signed(cfg_wdata_i[TempCfgW-1:0]);
        CFG_PERSONS:     persons_q     <= cfg_wdata_i[CountW-1:0];
        CFG_PER_PERSON:  per_person_q  <= $signed(cfg_wdata_i[TempCfgW-1:0]);
        CFG_EMERGENCY:   emergency_q   <= $signed(cfg_wdata_i[TempCfgW-1:0]);
        CFG_CYCLE_START: cycle_start_q <= cfg_wdata_i[TodW-1:0];
        default: ;
      endcase
    end
  end

  // Stop setpoint is base plus occupants times increment, exact.
  assign prod = $signed({1'b0, persons_q}) * per_person_q;

  always_comb begin
    cfg_o.mode      = mode_q;
    cfg_o.setpoint  = SetptW'(base_q) + SetptW'(prod);
    cfg_o.threshold = emergency_q;
    cfg_o.trigger   = TrigW'(cycle_start_q) + CycleDelaySeconds;
  end

endmodule

`default_nettype wire

// File: hw/rtl/whes_step.sv
// ----------------------------------------------------------------------------
// Water heater element sequencer step logic
// Computes the next sequencer state from the current state and one item.
// ----------------------------------------------------------------------------
`default_nettype none

module whes_step
  import whes_pkg::*;
(
  input  wire whes_cfg_t   cfg_i,
  input  wire whes_state_t state_i,
  input  wire whes_item_t  item_i,
  output whes_state_t      state_o
);

  logic                    temp_pos;
  logic                    below_emerg;
  logic                    at_setpoint;
  logic                    after_trig;
  logic                    before_trig;
  logic                    run_expired;
  logic signed [RiseW-1:0] rise;

  // Comparisons on the item against configuration and stored values.
  always_comb begin
    temp_pos    = item_i.tank_temp > 16'sd0;
    below_emerg = item_i.tank_temp < TempW'(cfg_i.threshold);
    at_setpoint = SetptW'(item_i.tank_temp) >= cfg_i.setpoint;
    after_trig  = TrigW'(item_i.time_of_day) > cfg_i.trigger;
    before_trig = TrigW'(item_i.time_of_day) < cfg_i.trigger;
    run_expired = (item_i.now_seconds - state_i.start_time) > RunCheckSeconds;
    rise        = RiseW'(item_i.tank_temp) - RiseW'(state_i.start_temp);
  end

  // Ordered update, following the check and poll rules.
  always_comb begin
    whes_state_t s;
    s = state_i;
    if (item_i.action == ACT_CHECK) begin
      if (cfg_i.mode != MODE_MANUAL) begin
        if (!s.heating && temp_pos && below_emerg) begin
          s = do_start(s, item_i.tank_temp, item_i.now_seconds);
        end
        if (s.heating && temp_pos && at_setpoint) begin
          s.relays  = '0;
          s.heating = 1'b0;
        end
      end
      if (cfg_i.mode == MODE_INTERMEDIATE || cfg_i.mode == MODE_SUMMER) begin
        if (!s.daily_done && !item_i.stove_running && after_trig) begin
          s            = do_start(s, item_i.tank_temp, item_i.now_seconds);
          s.daily_done = 1'b1;
        end else if (s.daily_done && before_trig) begin
          s.daily_done = 1'b0;
        end
      end
    end else begin
      if (s.heating && run_expired) begin
        s.start_time = item_i.now_seconds;
        if (rise < MinRiseHundredths) begin
          s = do_start(s, item_i.tank_temp, item_i.now_seconds);
        end
      end
    end
    state_o = s;
  end

endmodule

`default_nettype wire

// File: hw/rtl/water_heater_element_sequencer_core.sv
// Path: an accepted input is held in the input register, then moves on to the result register.
// Throughput: one item per cycle while the output is not stalled; the input register
// and the result register let one more item enter while a finished result waits downstream.
// The state update is one combinational step between those two registers.
// Reset: asynchronous, active low; state returns to idle, the first element started
// after reset is element zero, and all configuration registers read zero.
// ----------------------------------------------------------------------------
// Water heater element sequencer core
// Three-element heater sequencer with input, state and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module water_heater_element_sequencer_core
  import whes_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                action_i,
  input  wire logic signed [TempW-1:0] tank_temp_i,
  input  wire logic [TodW-1:0]     time_of_day_i,
  input  wire logic                stove_running_i,
  input  wire logic [NowW-1:0]     now_seconds_i,
  // Output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [DriveW-1:0]        element_drive_o,
  output logic                     heating_active_o,
  output logic [ElemW-1:0]         current_element_o
);

  whes_cfg_t   cfg;
  whes_item_t  item_q;
  logic        item_valid_q;
  whes_state_t state_q;
  whes_state_t state_d;
  logic        res_valid_q;
  logic        in_xfer;
  logic        advance;

  whes_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  whes_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d)
  );

  // Handshake: an item moves to the result register when that register is
  // free or being emptied in the same cycle.
  assign advance    = item_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_xfer) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.action        <= action_i;
      item_q.tank_temp     <= tank_temp_i;
      item_q.time_of_day   <= time_of_day_i;
      item_q.stove_running <= stove_running_i;
      item_q.now_seconds   <= now_seconds_i;
    end
  end

  // Sequencer state, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.heating    <= 1'b0;
      state_q.daily_done <= 1'b0;
      state_q.last_elem  <= LastElementIdx;
      state_q.relays     <= '0;
      state_q.start_temp <= '0;
      state_q.start_time <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      element_drive_o   <= state_d.relays;
      heating_active_o  <= state_d.heating;
      current_element_o <= state_d.last_elem;
    end
  end

  assign out_valid_o = res_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/whes_checker.sv
// ----------------------------------------------------------------------------
// Water heater element sequencer port checker
// Watches the top-level ports and flags results that break the sequencer rules.
// ----------------------------------------------------------------------------
`default_nettype none

module whes_checker
  import whes_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [DriveW-1:0] element_drive_o,
  input wire logic              heating_active_o,
  input wire logic [ElemW-1:0]  current_element_o
);

  // A stalled result stays and does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_drive_o)
      && $stable(heating_active_o) && $stable(current_element_o))
    else $error("stalled result changed");

  // At most one element is powered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(element_drive_o))
    else $error("more than one element driven");

  // Relays are powered exactly while heating is on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heating_active_o == (element_drive_o != '0)))
    else $error("relay drive disagrees with heating flag");

  // A powered relay is the selected element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && heating_active_o |->
      (element_drive_o[0] && current_element_o == 2'd0) ||
      (element_drive_o[1] && current_element_o == 2'd1) ||
      (element_drive_o[2] && current_element_o == 2'd2))
    else $error("relay drive does not match selected element");

endmodule

bind water_heater_element_sequencer_core whes_checker u_whes_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .element_drive_o   (element_drive_o),
  .heating_active_o  (heating_active_o),
  .current_element_o (current_element_o)
);

`default_nettype wire
